// ===== src/shp_pkg.sv =====
// Shared constants for the symbol hash probe table.
`timescale 1ns / 1ps
`default_nettype none
package shp_pkg;
	localparam int unsigned NAME_W     = 64;
	localparam int unsigned VALUE_W    = 16;
	localparam int unsigned SLOT_OUT_W = 11;
	localparam int unsigned KEY_W      = 16;
	localparam int unsigned DVD_W      = KEY_W + 1;
	localparam int unsigned CFG_W      = 12;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned APB_AW     = 3;
	localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 12'd1553;
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;
endpackage
`default_nettype wire

// ===== src/symbol_hash_probe_table.sv =====
// Symbol hash table engine with double-hashing probe sequence.
//
// Channel  Dir  Handshake                  Contents
// s_*      in   s_tvalid / s_tready        tuser op, tdata name and handle
// m_*      out  m_tvalid / m_tready        tdata slot, hit, handle, full flag
// APB      in   psel / penable / pready    table_size at address 0
//
// An item is taken in idle, then its key is built one byte a cycle (up to the first
// NUL, at most 8 bytes), then one shared restoring divider gives the base slot and
// the step, then each probe, starting one step below the base slot, is one RAM read,
// and the result is then offered on m_*. After reset a clearing pass empties every
// one of the TABLE_DEPTH entries before the first item is taken. One result may
// wait on m_* while the next item is already being worked on.
`timescale 1ns / 1ps
`default_nettype none
module symbol_hash_probe_table #(
	parameter int unsigned TABLE_DEPTH = 2048,
	parameter int unsigned NAME_BYTES  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic                         s_tuser,  // op
	input  wire logic [79:0]                  s_tdata,  // sym_name, entry_value
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic      [31:0]                  m_tdata,  // slot_index, hit, stored_value,
	                                                    // table_full, zero fill
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [shp_pkg::APB_AW-1:0]   paddr,
	input  wire logic [shp_pkg::APB_DW-1:0]   pwdata,
	output logic      [shp_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);
	import shp_pkg::*;

	localparam int unsigned AW    = $clog2(TABLE_DEPTH);
	localparam int unsigned SW    = AW + 1;
	localparam int unsigned RAM_W = 1 + NAME_W + VALUE_W;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_KEY, ST_DIV1, ST_DIV2, ST_ISSUE, ST_CHECK, ST_DONE
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    table_size_q;
	logic [AW-1:0]       clr_q;
	logic                op_q;
	logic [NAME_W-1:0]   name_q;
	logic [VALUE_W-1:0]  value_q;
	logic [SW-1:0]       size_q;
	logic [KEY_W-1:0]    key_q;
	logic [2:0]          byte_q;
	logic [4:0]          div_cnt_q;
	logic [DVD_W-1:0]    dvd_q;
	logic [DVD_W-1:0]    quo_q;
	logic [SW-1:0]       rem_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       step_q;
	logic [SW-1:0]       probes_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                res_hit_q;
	logic [VALUE_W-1:0]  res_val_q;
	logic                res_full_q;
	logic                m_tvalid_q;
	logic [31:0]         m_tdata_q;

	logic                cfg_wr;
	logic [SW-1:0]       size_eff;
	logic [NAME_W-1:0]   canon;
	logic [7:0]          cur_byte;
	logic [KEY_W-1:0]    key_sum;
	logic [SW:0]         trial;
	logic                trial_ge;
	logic [SW-1:0]       new_rem;
	logic [DVD_W-1:0]    new_quo;
	logic [SW-1:0]       next_slot;
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [RAM_W-1:0]    ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [RAM_W-1:0]    ram_rdata;
	logic                rd_valid;
	logic [NAME_W-1:0]   rd_name;
	logic [VALUE_W-1:0]  rd_value;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE);
	assign prdata = (paddr[2] == REG_TABLE_SIZE) ? APB_DW'(table_size_q) : '0;

	always_comb begin
		if (table_size_q == '0) begin
			size_eff = SW'(1);
		end else if (32'(table_size_q) > TABLE_DEPTH) begin
			size_eff = SW'(TABLE_DEPTH);
		end else begin
			size_eff = SW'(table_size_q);
		end
	end

	// Keep bytes up to the first NUL and within NAME_BYTES; the rest read as zero.
	always_comb begin
		logic live;
		live  = 1'b1;
		canon = '0;
		for (int j = 0; j < 8; j++) begin
			if (s_tdata[8*j +: 8] == 8'd0 || j >= int'(NAME_BYTES)) begin
				live = 1'b0;
			end
			if (live) begin
				canon[8*j +: 8] = s_tdata[8*j +: 8];
			end
		end
	end

	assign cur_byte = name_q[8*byte_q +: 8];
	assign key_sum  = key_q + KEY_W'(cur_byte);

	// One restoring-division step, shared by the slot and the step divisions.
	assign trial    = {rem_q, dvd_q[DVD_W-1]};
	assign trial_ge = trial >= {1'b0, size_q};
	assign new_rem  = trial_ge ? SW'(trial - {1'b0, size_q}) : SW'(trial);
	assign new_quo  = {quo_q[DVD_W-2:0], trial_ge};

	assign next_slot = (slot_q >= step_q) ? slot_q - step_q : slot_q + size_q - step_q;

	assign {rd_valid, rd_name, rd_value} = ram_rdata;
	assign ram_raddr = next_slot[AW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_q[AW-1:0];
		ram_wdata = {1'b1, name_q, value_q};
		if (state_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if (state_q == ST_CHECK && op_q == OP_INSERT
				&& (!rd_valid || rd_name == name_q)) begin
			ram_we = 1'b1;
		end
	end

	shp_ram #(
		.WIDTH (RAM_W),
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			table_size_q <= TABLE_SIZE_RESET;
			clr_q        <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (cfg_wr) begin
				table_size_q <= pwdata[CFG_W-1:0];
			end
			if (m_tvalid_q && m_tready && state_q != ST_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (32'(clr_q) == TABLE_DEPTH - 1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						op_q    <= s_tuser;
						name_q  <= canon;
						value_q <= s_tdata[79:64];
						size_q  <= size_eff;
						key_q   <= '0;
						byte_q  <= '0;
						state_q <= ST_KEY;
					end
				end
				ST_KEY: begin
					if (cur_byte == 8'd0) begin
						state_q <= ST_DIV1;
					end else begin
						key_q  <= {key_sum[7:0], key_sum[15:8]};
						byte_q <= byte_q + 1'b1;
						if (byte_q == 3'd7) begin
							state_q <= ST_DIV1;
						end
					end
					// The key enters the divider as the cycle leaves the key state.
					dvd_q     <= (cur_byte == 8'd0) ? DVD_W'(key_q)
						: DVD_W'({key_sum[7:0], key_sum[15:8]});
					quo_q     <= '0;
					rem_q     <= '0;
					div_cnt_q <= '0;
				end
				ST_DIV1: begin
					dvd_q     <= dvd_q << 1;
					quo_q     <= new_quo;
					rem_q     <= new_rem;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(DVD_W - 1)) begin
						slot_q    <= new_rem;
						dvd_q     <= new_quo + 1'b1;
						quo_q     <= '0;
						rem_q     <= '0;
						div_cnt_q <= '0;
						state_q   <= ST_DIV2;
					end
				end
				ST_DIV2: begin
					dvd_q     <= dvd_q << 1;
					quo_q     <= new_quo;
					rem_q     <= new_rem;
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == 5'(DVD_W - 1)) begin
						step_q  <= new_rem;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					slot_q   <= next_slot;
					probes_q <= SW'(1);
					state_q  <= ST_CHECK;
				end
				ST_CHECK: begin
					if (!rd_valid || rd_name == name_q) begin
						res_slot_q <= SLOT_OUT_W'(slot_q);
						res_hit_q  <= rd_valid;
						res_val_q  <= rd_valid ? rd_value : '0;
						res_full_q <= 1'b0;
						state_q    <= ST_DONE;
					end else if (probes_q == size_q) begin
						res_slot_q <= '0;
						res_hit_q  <= 1'b0;
						res_val_q  <= '0;
						res_full_q <= 1'b1;
						state_q    <= ST_DONE;
					end else begin
						slot_q   <= next_slot;
						probes_q <= probes_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {3'b000, res_full_q, res_val_q, res_hit_q, res_slot_q};
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/shp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module shp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule
`default_nettype wire
